/* rtl/core/tva_pkg.sv */
// tva_pkg: widths, stage counts and the cordic angle table for the
// triangle vertex angle pipeline; no dependencies
package tva_pkg;

	localparam int NORM_W       = 41;
	localparam int XY_W         = 44;
	localparam int Z_W          = 32;
	localparam int ZSCALE       = 24;
	localparam int NORM_STAGES  = 6;
	localparam int CORDIC_STEPS = 28;
	localparam int ANG_LAT      = 2 + NORM_STAGES + CORDIC_STEPS + 1;

	// atan(2^-i) in degrees * 2^24
	function automatic logic [Z_W-1:0] atan_tab(input int i);
		logic [Z_W-1:0] t;
		begin
			case (i)
				0:  t = 32'd754974720;
				1:  t = 32'd445687602;
				2:  t = 32'd235489088;
				3:  t = 32'd119537938;
				4:  t = 32'd60000934;
				5:  t = 32'd30029717;
				6:  t = 32'd15018523;
				7:  t = 32'd7509720;
				8:  t = 32'd3754917;
				9:  t = 32'd1877466;
				10: t = 32'd938734;
				11: t = 32'd469367;
				12: t = 32'd234684;
				13: t = 32'd117342;
				14: t = 32'd58671;
				15: t = 32'd29335;
				16: t = 32'd14668;
				17: t = 32'd7334;
				18: t = 32'd3667;
				19: t = 32'd1833;
				20: t = 32'd917;
				21: t = 32'd458;
				22: t = 32'd229;
				23: t = 32'd115;
				24: t = 32'd57;
				25: t = 32'd29;
				26: t = 32'd14;
				27: t = 32'd7;
				default: t = '0;
			endcase
			return t;
		end
	endfunction

	// normalize step j shifts by 32, 16, 8, 4, 2, 1
	function automatic int norm_shift(input int j);
		return 32 >> j;
	endfunction

endpackage

/* rtl/core/tva_angle.sv */
// tva_angle: pipelined angle between two integer vectors, atan2 of
// cross and dot by normalize and cordic stages; depends on tva_pkg
module tva_angle #(
	parameter int COORD_BITS = 13,
	parameter int FRAC_BITS  = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_v,
	input  logic signed [COORD_BITS:0] ux,
	input  logic signed [COORD_BITS:0] uy,
	input  logic signed [COORD_BITS:0] vx,
	input  logic signed [COORD_BITS:0] vy,
	output logic                       out_v,
	output logic [15:0]                angle
);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int DOT_W  = PROD_W + 1;
	localparam int NW     = tva_pkg::NORM_W;
	localparam int XW     = tva_pkg::XY_W;
	localparam int ZW     = tva_pkg::Z_W;
	localparam int NS     = tva_pkg::NORM_STAGES;
	localparam int CS     = tva_pkg::CORDIC_STEPS;
	localparam logic signed [ZW-1:0] Z90 = ZW'(90 << tva_pkg::ZSCALE);
	localparam logic signed [ZW-1:0] RND = ZW'(1 << (tva_pkg::ZSCALE - 1 - FRAC_BITS));
	localparam logic signed [ZW-1:0] A180 = ZW'(180 << FRAC_BITS);
	localparam logic signed [ZW-1:0] A90 = ZW'(90 << FRAC_BITS);

	typedef struct packed {
		logic cr_zero;
		logic dot_zero;
		logic dot_neg;
	} flags_t;

	logic                     v_s1, v_s2;
	logic signed [PROD_W-1:0] pxx_s1, pyy_s1, pxy_s1, pyx_s1;
	logic [DOT_W-1:0]         dmag_s2, cmag_s2;
	flags_t                   f_s2;
	logic signed [DOT_W-1:0]  dot_c, cr_c;

	always_comb begin
		dot_c = DOT_W'(pxx_s1) + DOT_W'(pyy_s1);
		cr_c  = DOT_W'(pxy_s1) - DOT_W'(pyx_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pxx_s1     <= ux * vx;
		pyy_s1     <= uy * vy;
		pxy_s1     <= ux * vy;
		pyx_s1     <= uy * vx;
		dmag_s2    <= dot_c[DOT_W-1] ? DOT_W'(-dot_c) : DOT_W'(dot_c);
		cmag_s2    <= cr_c[DOT_W-1] ? DOT_W'(-cr_c) : DOT_W'(cr_c);
		f_s2.cr_zero  <= (cr_c == '0);
		f_s2.dot_zero <= (dot_c == '0);
		f_s2.dot_neg  <= dot_c[DOT_W-1];
	end

	// normalize: shift both until the larger has bit NW-1 set
	logic [NW-1:0] nx_s [0:NS];
	logic [NW-1:0] ny_s [0:NS];
	flags_t        nf_s [0:NS];
	logic          nv_s [0:NS];

	assign nx_s[0] = NW'(dmag_s2);
	assign ny_s[0] = NW'(cmag_s2);
	assign nf_s[0] = f_s2;
	assign nv_s[0] = v_s2;

	for (genvar j = 0; j < NS; j++) begin : g_norm
		localparam int K = tva_pkg::norm_shift(j);
		logic small_c;
		assign small_c = (((nx_s[j] | ny_s[j]) >> (NW - K)) == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nv_s[j+1] <= 1'b0;
			end else begin
				nv_s[j+1] <= nv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			nx_s[j+1] <= small_c ? (nx_s[j] << K) : nx_s[j];
			ny_s[j+1] <= small_c ? (ny_s[j] << K) : ny_s[j];
			nf_s[j+1] <= nf_s[j];
		end
	end

	// cordic vectoring, one step per stage
	logic signed [XW-1:0] cx_s [0:CS];
	logic signed [XW-1:0] cy_s [0:CS];
	logic signed [ZW-1:0] cz_s [0:CS];
	flags_t               cf_s [0:CS];
	logic                 cv_s [0:CS];

	assign cx_s[0] = signed'(XW'(nx_s[NS]));
	assign cy_s[0] = signed'(XW'(ny_s[NS]));
	assign cz_s[0] = '0;
	assign cf_s[0] = nf_s[NS];
	assign cv_s[0] = nv_s[NS];

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		logic signed [XW-1:0] xs_c, ys_c, yneg_c;
		logic                 pos_c;
		assign pos_c  = !cy_s[i][XW-1] && (cy_s[i] != '0);
		assign yneg_c = -cy_s[i];
		assign xs_c   = cx_s[i] >>> i;
		assign ys_c   = cy_s[i][XW-1] ? -(yneg_c >>> i) : (cy_s[i] >>> i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			cf_s[i+1] <= cf_s[i];
			if (pos_c) begin
				cx_s[i+1] <= cx_s[i] + ys_c;
				cy_s[i+1] <= cy_s[i] - xs_c;
				cz_s[i+1] <= cz_s[i] + signed'(tva_pkg::atan_tab(i));
			end else begin
				cx_s[i+1] <= cx_s[i] - ys_c;
				cy_s[i+1] <= cy_s[i] + xs_c;
				cz_s[i+1] <= cz_s[i] - signed'(tva_pkg::atan_tab(i));
			end
		end
	end

	// clamp, round, fold and exact cases
	logic signed [ZW-1:0] res_c;
	always_comb begin
		logic signed [ZW-1:0] zc;
		logic signed [ZW-1:0] r;
		zc = cz_s[CS];
		if (zc[ZW-1])
			zc = '0;
		else if (zc > Z90)
			zc = Z90;
		r = (zc + RND) >>> (tva_pkg::ZSCALE - FRAC_BITS);
		if (cf_s[CS].dot_neg)
			r = A180 - r;
		if (cf_s[CS].cr_zero)
			r = cf_s[CS].dot_neg ? A180 : '0;
		else if (cf_s[CS].dot_zero)
			r = A90;
		res_c = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else begin
			out_v <= cv_s[CS];
		end
	end

	always_ff @(posedge clk) begin
		angle <= res_c[15:0];
	end

	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		nv_s[NS] && !nf_s[NS].cr_zero && !nf_s[NS].dot_zero
		|-> (nx_s[NS][NW-1] || ny_s[NS][NW-1]))
		else $error("normalized word lacks its top bit");

	a_x_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cv_s[CS] && !cf_s[CS].cr_zero && !cf_s[CS].dot_zero |-> !cx_s[CS][XW-1])
		else $error("cordic x went negative");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && FRAC_BITS <= 8 |-> (32'(angle) <= (180 << FRAC_BITS)))
		else $error("angle above 180 degrees");

endmodule

/* rtl/core/triangle_vertex_angles.sv */
// triangle_vertex_angles: top level, angles at the third and first point
// depends on tva_pkg and tva_angle
// start goes via v_s1, both angle units and the done register; one word per cycle
// busy stays low: a word may start in every cycle and the pipeline never stalls
// the two angle units run side by side, 2 product/dot, 6 normalize, 28 cordic stages
// asynchronous reset clears the valid bits only; done is low after reset
module triangle_vertex_angles #(
	parameter int COORD_BITS = 13,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	output logic                         done,
	output logic [15:0]                  angle_at_third,
	output logic [15:0]                  angle_at_first,
	output logic                         degenerate
);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int LAT    = tva_pkg::ANG_LAT;

	typedef struct packed {
		logic kill3;
		logic kill1;
		logic degen;
	} flags_t;

	logic                     v_s1;
	logic signed [DIFF_W-1:0] u3x_s1, u3y_s1, v3x_s1, v3y_s1;
	logic signed [DIFF_W-1:0] u1x_s1, u1y_s1, v1x_s1, v1y_s1;
	flags_t                   f_s1;
	logic                     z12_c, z23_c, z13_c;

	assign busy  = 1'b0;
	assign z12_c = (ax == bx) && (ay == by);
	assign z23_c = (bx == cx) && (by == cy);
	assign z13_c = (ax == cx) && (ay == cy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		u3x_s1 <= DIFF_W'(bx) - DIFF_W'(cx);
		u3y_s1 <= DIFF_W'(by) - DIFF_W'(cy);
		v3x_s1 <= DIFF_W'(ax) - DIFF_W'(cx);
		v3y_s1 <= DIFF_W'(ay) - DIFF_W'(cy);
		u1x_s1 <= DIFF_W'(bx) - DIFF_W'(ax);
		u1y_s1 <= DIFF_W'(by) - DIFF_W'(ay);
		v1x_s1 <= DIFF_W'(cx) - DIFF_W'(ax);
		v1y_s1 <= DIFF_W'(cy) - DIFF_W'(ay);
		f_s1.kill3 <= z23_c || z13_c;
		f_s1.kill1 <= z12_c || z13_c;
		f_s1.degen <= z12_c || z23_c || z13_c;
	end

	logic        a3_v, a1_v;
	logic [15:0] a3, a1;

	tva_angle #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_third (
		.clk   (clk),
		.arst_n(arst_n),
		.in_v  (v_s1),
		.ux    (u3x_s1),
		.uy    (u3y_s1),
		.vx    (v3x_s1),
		.vy    (v3y_s1),
		.out_v (a3_v),
		.angle (a3)
	);

	tva_angle #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_first (
		.clk   (clk),
		.arst_n(arst_n),
		.in_v  (v_s1),
		.ux    (u1x_s1),
		.uy    (u1y_s1),
		.vx    (v1x_s1),
		.vy    (v1y_s1),
		.out_v (a1_v),
		.angle (a1)
	);

	// flags ride alongside the angle units
	flags_t fd_s [0:LAT];
	assign fd_s[0] = f_s1;
	for (genvar k = 0; k < LAT; k++) begin : g_fdly
		always_ff @(posedge clk) begin
			fd_s[k+1] <= fd_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= a3_v && a1_v;
		end
	end

	always_ff @(posedge clk) begin
		angle_at_third <= fd_s[LAT].kill3 ? 16'd0 : a3;
		angle_at_first <= fd_s[LAT].kill1 ? 16'd0 : a1;
		degenerate     <= fd_s[LAT].degen;
	end

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(LAT + 2) done)
		else $error("word lost in pipeline");

	a_no_spur: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##(LAT + 2) !done)
		else $error("done without a started word");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate && FRAC_BITS <= 8
		|-> (32'(angle_at_third) + 32'(angle_at_first) <= (180 << FRAC_BITS) + 2))
		else $error("angle sum above 180 degrees");

endmodule

/* verif/testbench.sv */
// testbench: random and directed point triples into triangle_vertex_angles,
// angles checked against an in-bench cordic atan2 predictor on cross and dot
// depends on tva_pkg and the triangle_vertex_angles rtl
`timescale 1ns / 1ps

module testbench;

	localparam int CB = 13;
	localparam int FB = 8;
	localparam int N_RANDOM = 1100;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
		int gap;
	} tri_word_t;

	typedef struct {
		logic [15:0] a3, a1;
		logic        degen;
	} angle_word_t;

	logic clk = 0, arst_n = 0, start = 0;
	logic signed [CB-1:0] ax = 0, ay = 0, bx = 0, by = 0, cx = 0, cy = 0;
	wire busy, done, degenerate;
	wire [15:0] angle_at_third, angle_at_first;

	tri_word_t   pending[$];
	angle_word_t expected_angles[$];
	int mismatches = 0, checked = 0, cycles = 0, degen_seen = 0;
	int wait_left = 0;
	bit hold_for_drain = 0;
	bit stim_done = 0;

	triangle_vertex_angles #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
		.done(done), .angle_at_third(angle_at_third),
		.angle_at_first(angle_at_first), .degenerate(degenerate)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint shift_tz(longint v, int n);
		if (v < 0)
			return -((-v) >>> n);
		return v >>> n;
	endfunction

	function automatic longint vertex_angle(longint ux, longint uy, longint vx, longint vy);
		longint dp, cr, x, y, z, r, xs, ys;
		dp = ux * vx + uy * vy;
		cr = ux * vy - uy * vx;
		z = 0;
		if (cr < 0)
			cr = -cr;
		if (cr == 0)
			return dp > 0 ? 0 : (longint'(180) << FB);
		if (dp == 0)
			return longint'(90) << FB;
		x = dp < 0 ? -dp : dp;
		y = cr;
		while (x < (longint'(1) << 40) && y < (longint'(1) << 40)) begin
			x = x << 1;
			y = y << 1;
		end
		for (int i = 0; i < tva_pkg::CORDIC_STEPS; i++) begin
			xs = shift_tz(x, i);
			ys = shift_tz(y, i);
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z += longint'(tva_pkg::atan_tab(i));
			end else begin
				x = x - ys;
				y = y + xs;
				z -= longint'(tva_pkg::atan_tab(i));
			end
		end
		if (z < 0)
			z = 0;
		if (z > (longint'(90) << tva_pkg::ZSCALE))
			z = longint'(90) << tva_pkg::ZSCALE;
		r = (z + (longint'(1) << (tva_pkg::ZSCALE - 1 - FB))) >>> (tva_pkg::ZSCALE - FB);
		if (dp < 0)
			r = (longint'(180) << FB) - r;
		return r;
	endfunction

	function automatic angle_word_t predict_angles(tri_word_t t);
		angle_word_t w;
		longint x1, y1, x2, y2, x3, y3;
		bit z12, z23, z13;
		x1 = t.ax; y1 = t.ay; x2 = t.bx; y2 = t.by; x3 = t.cx; y3 = t.cy;
		z12 = (x1 == x2) && (y1 == y2);
		z23 = (x2 == x3) && (y2 == y3);
		z13 = (x1 == x3) && (y1 == y3);
		w.a3 = '0;
		w.a1 = '0;
		if (!z23 && !z13)
			w.a3 = 16'(vertex_angle(x2 - x3, y2 - y3, x1 - x3, y1 - y3));
		if (!z12 && !z13)
			w.a1 = 16'(vertex_angle(x2 - x1, y2 - y1, x3 - x1, y3 - y1));
		w.degen = z12 || z23 || z13;
		return w;
	endfunction

	task automatic add_tri(int a0, int a1, int b0, int b1, int c0, int c1, int g);
		tri_word_t t;
		t.ax = CB'(a0); t.ay = CB'(a1); t.bx = CB'(b0); t.by = CB'(b1);
		t.cx = CB'(c0); t.cy = CB'(c1);
		t.gap = g;
		pending = {pending, t};
	endtask

	function automatic int rand_coord(int mode);
		case (mode)
			0: return int'($urandom_range(0, 8191)) - 4096;
			1: return int'($urandom_range(0, 16)) - 8;
			default: return $urandom_range(0, 1) ? 4095 : -4096;
		endcase
	endfunction

	// driver
	always @(posedge clk) begin
		tri_word_t t;
		bit go;
		go = 0;
		if (arst_n) begin
			if (start && busy) begin
				go = 1;
			end else begin
				if (start)
					expected_angles = {expected_angles,
						predict_angles(tri_word_t'{ax, ay, bx, by, cx, cy, 0})};
				if (hold_for_drain) begin
					if (expected_angles.size() == 0)
						hold_for_drain <= 0;
				end else if (wait_left > 0) begin
					wait_left <= wait_left - 1;
				end else if (pending.size() > 0) begin
					t = pending.pop_front();
					if (t.gap < 0) begin
						hold_for_drain <= 1;
					end else begin
						ax <= t.ax; ay <= t.ay; bx <= t.bx; by <= t.by;
						cx <= t.cx; cy <= t.cy;
						go = 1;
						wait_left <= t.gap;
					end
				end else begin
					stim_done <= 1;
				end
			end
			start <= go;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			angle_word_t e;
			if (expected_angles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: %0d %0d %0d",
						angle_at_third, angle_at_first, degenerate);
			end else begin
				e = expected_angles.pop_front();
				checked++;
				if (e.degen)
					degen_seen++;
				if (e.a3 !== angle_at_third || e.a1 !== angle_at_first ||
						e.degen !== degenerate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
							e.a3, e.a1, e.degen,
							angle_at_third, angle_at_first, degenerate);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		int m, g;
		// extremes, right angle, collinear, degenerate cases
		add_tri(0, 0, 0, 0, 0, 0, 0);
		add_tri(-4096, -4096, 4095, 4095, 0, 0, 0);
		add_tri(-4096, -4096, 4095, 4095, -4096, 4095, 0);
		add_tri(4095, -4096, -4096, 4095, 4095, 4095, 0);
		add_tri(0, 0, 10, 0, 0, 10, 0);
		add_tri(0, 0, 10, 0, 5, 0, 0);
		add_tri(0, 0, 10, 0, 20, 0, 0);
		add_tri(-4096, 0, 4095, 0, 0, 0, 0);
		add_tri(1, 1, 1, 1, 5, 7, 0);
		add_tri(1, 1, 5, 7, 5, 7, 0);
		add_tri(1, 1, 5, 7, 1, 1, 0);
		add_tri(-4096, -4096, -4096, -4095, 4095, 4095, 0);
		add_tri(4095, 4095, -4096, -4096, 4095, 4094, 0);
		add_tri(0, 0, 1, 0, 0, 1, 0);
		add_tri(0, 0, 3, 4, -4, 3, 0);
		add_tri(100, 100, 101, 101, -4096, 4095, 0);
		add_tri(0, 0, 0, 0, 0, 0, -1);
		for (int i = 0; i < N_RANDOM; i++) begin
			m = $urandom_range(0, 9);
			m = m < 6 ? 0 : (m < 9 ? 1 : 2);
			g = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
			if (i == N_RANDOM / 2)
				add_tri(0, 0, 0, 0, 0, 0, -1);
			add_tri(rand_coord(m), rand_coord(m), rand_coord(m), rand_coord(m),
				rand_coord(m), rand_coord(m), g);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1;
		wait (stim_done && expected_angles.size() == 0);
		repeat (60) @(posedge clk);
		$display("checked %0d words, %0d with a zero-length side", checked, degen_seen);
		if (mismatches == 0 && expected_angles.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
